### rtl/bsm_pkg.sv
package bsm_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int RAD_W     = 31;
   // per-axis difference and its magnitude
   localparam int DIFF_W    = COORD_W + 1;
   localparam int MAG_W     = COORD_W + 1;
   localparam int PROD_W    = 2 * MAG_W;
   // sum of three squares, padded to an even number of bits
   localparam int SUM_W     = PROD_W + 4;
   localparam int ROOT_W    = SUM_W / 2;
   // division numerator/denominator and quotient
   localparam int DIV_W     = ROOT_W + 2;
   localparam int QUOT_W    = FRAC_BITS + 1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [RAD_W-1:0]          radius_type;
   typedef logic [MAG_W-1:0]          mag_type;
   typedef logic [PROD_W-1:0]         prod_type;

endpackage

### rtl/bsm_if.sv
interface bsm_req_if
   import bsm_pkg::*;
();
   logic       valid;
   logic       ready;
   coord_type  in_x;
   coord_type  in_y;
   coord_type  in_z;
   radius_type in_radius;
   coord_type  in_weight;
   logic       start_new;

   modport source (output valid, in_x, in_y, in_z, in_radius, in_weight, start_new,
                   input ready);
   modport sink   (input valid, in_x, in_y, in_z, in_radius, in_weight, start_new,
                   output ready);
endinterface

interface bsm_rsp_if
   import bsm_pkg::*;
();
   logic       valid;
   logic       ready;
   coord_type  out_x;
   coord_type  out_y;
   coord_type  out_z;
   radius_type out_radius;
   coord_type  out_weight;
   logic       saturated;

   modport source (output valid, out_x, out_y, out_z, out_radius, out_weight, saturated,
                   input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_radius, out_weight, saturated,
                   output ready);
endinterface

### rtl/bsm_mul.sv
// Shift-add multiplier: one multiplier bit per cycle.
module bsm_mul
   import bsm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  mag_type  a,
   input  mag_type  b,
   output prod_type product,
   output logic     done
);

   localparam int CNT_W = $clog2(MAG_W);

   mag_type          a_ff;
   mag_type          hi_ff, hi_in;
   mag_type          lo_ff, lo_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [MAG_W:0]   sum;

   always_comb begin
      sum   = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, a_ff} : {(MAG_W+1){1'b0}});
      hi_in = sum[MAG_W:1];
      lo_in = {sum[0], lo_ff[MAG_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAG_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= a;
         hi_ff <= '0;
         lo_ff <= b;
      end else if (busy_ff) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign product = {hi_ff, lo_ff};
   assign done    = done_ff;

endmodule

### rtl/bsm_isqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module bsm_isqrt
   import bsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  radicand,
   output logic [ROOT_W-1:0] root,
   output logic              done
);

   localparam int REM_W = ROOT_W + 3;
   localparam int CNT_W = $clog2(ROOT_W);

   logic [SUM_W-1:0]  val_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [REM_W+1:0]  rsh;
   logic [REM_W+1:0]  trial;
   logic [REM_W+1:0]  diff;
   logic              ge;

   always_comb begin
      rsh   = {rem_ff, val_ff[SUM_W-1 -: 2]};
      trial = {{(REM_W-ROOT_W){1'b0}}, root_ff, 2'b01};
      ge    = (rsh >= trial);
      diff  = rsh - trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         val_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         val_ff  <= {val_ff[SUM_W-3:0], 2'b00};
         rem_ff  <= ge ? diff[REM_W-1:0] : rsh[REM_W-1:0];
         root_ff <= {root_ff[ROOT_W-2:0], ge};
      end
   end

   assign root = root_ff;
   assign done = done_ff;

endmodule

### rtl/bsm_div.sv
// Restoring divider, one quotient bit per cycle. Caller guarantees num <= 2*den.
module bsm_div
   import bsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIV_W-1:0]  num,
   input  logic [DIV_W-1:0]  den,
   output logic [QUOT_W-1:0] quot,
   output logic              done
);

   localparam int CNT_W = $clog2(QUOT_W);

   logic [DIV_W:0]    rem_ff;
   logic [DIV_W-1:0]  den_ff;
   logic [QUOT_W-1:0] q_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic              ge;
   logic [DIV_W:0]    rest;

   always_comb begin
      ge   = (rem_ff >= {1'b0, den_ff});
      rest = ge ? (rem_ff - {1'b0, den_ff}) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, num};
         den_ff <= den;
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= {rest[DIV_W-1:0], 1'b0};
         q_ff   <= {q_ff[QUOT_W-2:0], ge};
      end
   end

   assign quot = q_ff;
   assign done = done_ff;

endmodule

### rtl/bounding_sphere_merge.sv
// Empty, copy and equal-centre items skip the arithmetic; when one sphere contains the
// other, squaring and root run first; a true merge runs squaring, root, division and
// centre offsets on the bit-serial units, plus control states.
// One item in flight; input reopens with the result, and the next beat is taken while a
// result waits.
// Synchronous reset clears the running sphere and weight to zero.
module bounding_sphere_merge
   import bsm_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   bsm_req_if.sink   req,
   bsm_rsp_if.source rsp
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_PREP = 4'd1;
   localparam logic [3:0] S_SQGO = 4'd2;
   localparam logic [3:0] S_SQ   = 4'd3;
   localparam logic [3:0] S_SUM  = 4'd4;
   localparam logic [3:0] S_SQRT = 4'd5;
   localparam logic [3:0] S_CASE = 4'd6;
   localparam logic [3:0] S_DIV  = 4'd7;
   localparam logic [3:0] S_MVGO = 4'd8;
   localparam logic [3:0] S_MOV  = 4'd9;
   localparam logic [3:0] S_OUT  = 4'd10;

   localparam int W36 = ROOT_W + 1;
   localparam logic [QUOT_W-1:0] T_ONE = QUOT_W'(1) << FRAC_BITS;

   logic [3:0] state_ff, state_in;

   coord_type  acc_x_ff, acc_y_ff, acc_z_ff, acc_w_ff;
   radius_type acc_r_ff;
   coord_type  in_x_ff, in_y_ff, in_z_ff, in_w_ff;
   radius_type in_r_ff;
   logic       sat_ff;

   logic signed [DIFF_W-1:0] d_ff [3];
   mag_type                  mag_ff [3];
   logic [SUM_W-1:0]         sum_ff;
   logic [ROOT_W-1:0]        dist_ff;
   logic [QUOT_W-1:0]        t_ff;
   logic [W36-1:0]           rad_ff;
   logic [DIV_W-1:0]         num_ff, den_ff;

   logic       rsp_valid_ff;
   coord_type  rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_w_ff;
   radius_type rsp_r_ff;
   logic       rsp_sat_ff;

   // datapath helpers
   logic                     accept;
   coord_type                base_x, base_y, base_z, base_w;
   radius_type               base_r;
   logic signed [DIFF_W-1:0] dd [3];
   mag_type                  md [3];
   coord_type                acc_c [3];
   mag_type                  mul_b [3];
   prod_type                 prod [3];
   logic [2:0]               mul_done;
   logic                     mul_start;
   logic [ROOT_W-1:0]        root;
   logic                     sqrt_done;
   logic [QUOT_W-1:0]        quot;
   logic                     div_done;
   logic [W36-1:0]           dist_r2, dist_r1;
   logic [W36:0]             rad_sum;
   logic signed [MAG_W+1:0]  n_val [3];
   logic [MAG_W:0]           off [3];
   coord_type                n_clip [3];
   logic [2:0]               n_sat;
   logic [DIV_W-1:0]         num_c, den_c;

   assign accept    = (state_ff == S_IDLE) && req.valid;
   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      base_x = req.start_new ? '0 : acc_x_ff;
      base_y = req.start_new ? '0 : acc_y_ff;
      base_z = req.start_new ? '0 : acc_z_ff;
      base_r = req.start_new ? '0 : acc_r_ff;
      base_w = req.start_new ? '0 : acc_w_ff;
      if (base_w < req.in_weight) begin
         base_w = req.in_weight;
      end
   end

   assign acc_c[0] = acc_x_ff;
   assign acc_c[1] = acc_y_ff;
   assign acc_c[2] = acc_z_ff;

   always_comb begin
      dd[0] = DIFF_W'(in_x_ff) - DIFF_W'(acc_x_ff);
      dd[1] = DIFF_W'(in_y_ff) - DIFF_W'(acc_y_ff);
      dd[2] = DIFF_W'(in_z_ff) - DIFF_W'(acc_z_ff);
      for (int i = 0; i < 3; i++) begin
         md[i] = dd[i][DIFF_W-1] ? mag_type'(-dd[i]) : mag_type'(dd[i]);
      end
   end

   assign mul_start = (state_ff == S_SQGO) || (state_ff == S_MVGO);

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_axis
         assign mul_b[g] = (state_ff == S_SQGO) ? mag_ff[g] : MAG_W'(t_ff);
         bsm_mul u_mul (
            .clock   (clock),
            .reset   (reset),
            .start   (mul_start),
            .a       (mag_ff[g]),
            .b       (mul_b[g]),
            .product (prod[g]),
            .done    (mul_done[g])
         );
      end
   endgenerate

   bsm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_SUM),
      .radicand (sum_ff),
      .root     (root),
      .done     (sqrt_done)
   );

   bsm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_CASE),
      .num   (num_ff),
      .den   (den_ff),
      .quot  (quot),
      .done  (div_done)
   );

   always_comb begin
      dist_r2 = W36'(dist_ff) + W36'(in_r_ff);
      dist_r1 = W36'(dist_ff) + W36'(acc_r_ff);
      rad_sum = (W36+1)'(dist_r1) + (W36+1)'(in_r_ff);
   end

   // divider operands taken from the fresh root so they are ready in S_CASE
   always_comb begin
      num_c = DIV_W'(root) + DIV_W'(in_r_ff) - DIV_W'(acc_r_ff);
      den_c = DIV_W'({root, 1'b0});
   end

   // centre move: a +/- floor(|d| * t >> FRAC_BITS), clipped to 32 bits
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         off[i]   = prod[i][FRAC_BITS +: (MAG_W+1)];
         n_val[i] = d_ff[i][DIFF_W-1]
                  ? ((MAG_W+2)'(acc_c[i]) - $signed({1'b0, off[i]}))
                  : ((MAG_W+2)'(acc_c[i]) + $signed({1'b0, off[i]}));
         n_sat[i]  = 1'b1;
         n_clip[i] = n_val[i][COORD_W-1:0];
         if (n_val[i] > (MAG_W+2)'(32'sh7FFF_FFFF)) begin
            n_clip[i] = 32'sh7FFF_FFFF;
         end else if (n_val[i] < -(MAG_W+2)'(33'sh0_8000_0000)) begin
            n_clip[i] = 32'sh8000_0000;
         end else begin
            n_sat[i] = 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_PREP;
         S_PREP: begin
            if (in_r_ff == '0 || acc_r_ff == '0 || (dd[0] == '0 && dd[1] == '0 && dd[2] == '0))
               state_in = S_OUT;
            else
               state_in = S_SQGO;
         end
         S_SQGO: state_in = S_SQ;
         S_SQ:   if (mul_done[0]) state_in = S_SUM;
         S_SUM:  state_in = S_SQRT;
         S_SQRT: if (sqrt_done) state_in = S_CASE;
         S_CASE: begin
            if ((W36'(acc_r_ff) > dist_r2) || (dist_r1 < W36'(in_r_ff)))
               state_in = S_OUT;
            else
               state_in = S_DIV;
         end
         S_DIV:  if (div_done) state_in = S_MVGO;
         S_MVGO: state_in = S_MOV;
         S_MOV:  if (mul_done[0]) state_in = S_OUT;
         S_OUT:  if (!rsp_valid_ff || rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         acc_x_ff     <= '0;
         acc_y_ff     <= '0;
         acc_z_ff     <= '0;
         acc_r_ff     <= '0;
         acc_w_ff     <= '0;
         sat_ff       <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp.ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  acc_x_ff <= base_x;
                  acc_y_ff <= base_y;
                  acc_z_ff <= base_z;
                  acc_r_ff <= base_r;
                  acc_w_ff <= base_w;
                  sat_ff   <= 1'b0;
               end
            end
            S_PREP: begin
               if (in_r_ff != '0) begin
                  if (acc_r_ff == '0) begin
                     acc_x_ff <= in_x_ff;
                     acc_y_ff <= in_y_ff;
                     acc_z_ff <= in_z_ff;
                     acc_r_ff <= in_r_ff;
                     acc_w_ff <= in_w_ff;
                  end else if (dd[0] == '0 && dd[1] == '0 && dd[2] == '0) begin
                     if (in_r_ff > acc_r_ff) acc_r_ff <= in_r_ff;
                  end
               end
            end
            S_CASE: begin
               // input containing the running sphere replaces it
               if (!(W36'(acc_r_ff) > dist_r2) && (dist_r1 < W36'(in_r_ff))) begin
                  acc_x_ff <= in_x_ff;
                  acc_y_ff <= in_y_ff;
                  acc_z_ff <= in_z_ff;
                  acc_r_ff <= in_r_ff;
               end
            end
            S_MOV: begin
               if (mul_done[0]) begin
                  acc_x_ff <= n_clip[0];
                  acc_y_ff <= n_clip[1];
                  acc_z_ff <= n_clip[2];
                  if (rad_ff > W36'(31'h7FFF_FFFF)) begin
                     acc_r_ff <= 31'h7FFF_FFFF;
                     sat_ff   <= 1'b1;
                  end else begin
                     acc_r_ff <= rad_ff[RAD_W-1:0];
                     sat_ff   <= |n_sat;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_x_ff <= req.in_x;
         in_y_ff <= req.in_y;
         in_z_ff <= req.in_z;
         in_r_ff <= req.in_radius;
         in_w_ff <= req.in_weight;
      end
      if (state_ff == S_PREP) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i]   <= dd[i];
            mag_ff[i] <= md[i];
         end
      end
      if (state_ff == S_SQ && mul_done[0]) begin
         sum_ff <= SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
      end
      if (state_ff == S_SQRT && sqrt_done) begin
         dist_ff <= root;
      end
      if (state_ff == S_CASE) begin
         rad_ff <= rad_sum[W36:1];
      end
      if (state_ff == S_SQRT && sqrt_done) begin
         num_ff <= num_c;
         den_ff <= den_c;
      end
      if (state_ff == S_DIV && div_done) begin
         t_ff <= (quot > T_ONE) ? T_ONE : quot;
      end
      if (state_ff == S_OUT && (!rsp_valid_ff || rsp.ready)) begin
         rsp_x_ff   <= acc_x_ff;
         rsp_y_ff   <= acc_y_ff;
         rsp_z_ff   <= acc_z_ff;
         rsp_r_ff   <= acc_r_ff;
         rsp_w_ff   <= acc_w_ff;
         rsp_sat_ff <= sat_ff;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_x      = rsp_x_ff;
   assign rsp.out_y      = rsp_y_ff;
   assign rsp.out_z      = rsp_z_ff;
   assign rsp.out_radius = rsp_r_ff;
   assign rsp.out_weight = rsp_w_ff;
   assign rsp.saturated  = rsp_sat_ff;

endmodule

### tb/sv/testbench.sv
module testbench;
   import bsm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      coord_type  x;
      coord_type  y;
      coord_type  z;
      radius_type radius;
      coord_type  weight;
      logic       start_new;
   } sphere_in_type;

   typedef struct packed {
      coord_type  x;
      coord_type  y;
      coord_type  z;
      radius_type radius;
      coord_type  weight;
      logic       saturated;
   } sphere_out_type;

   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 400;

   logic clock;
   logic reset;

   bsm_req_if req_if ();
   bsm_rsp_if rsp_if ();

   bounding_sphere_merge dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   // running sphere as the block should hold it
   coord_type      run_x, run_y, run_z, run_weight;
   radius_type     run_radius;
   sphere_out_type pending_spheres[$];

   int errors = 0;
   int beats_sent = 0;
   int beats_checked = 0;
   int merges_seen = 0;
   int sat_seen = 0;
   int idle_cycles = 0;
   bit hold_rsp = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint unsigned mag33(longint signed v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic coord_type shift_axis(longint signed a, longint signed d,
                                            longint unsigned t, ref bit sat);
      longint unsigned off;
      longint signed n;
      off = (mag33(d) * t) >> FRAC_BITS;
      n = (d < 0) ? a - longint'(off) : a + longint'(off);
      if (n > 64'sd2147483647) begin
         n = 64'sd2147483647;
         sat = 1;
      end
      if (n < -64'sd2147483648) begin
         n = -64'sd2147483648;
         sat = 1;
      end
      return coord_type'(n[31:0]);
   endfunction

   function automatic sphere_out_type fold_sphere(sphere_in_type s);
      sphere_out_type o;
      bit sat;
      longint signed ax, ay, az, dx, dy, dz, r1, r2, cdist;
      logic [71:0] sum, sq;
      logic [35:0] root, cand;
      longint unsigned num, den, t, rad;
      sat = 0;
      if (s.start_new) begin
         run_x = '0; run_y = '0; run_z = '0; run_radius = '0; run_weight = '0;
      end
      if (run_weight < s.weight)
         run_weight = s.weight;
      if (s.radius != 0) begin
         if (run_radius == 0) begin
            run_x = s.x; run_y = s.y; run_z = s.z;
            run_radius = s.radius;
            run_weight = s.weight;
         end else begin
            ax = run_x; ay = run_y; az = run_z;
            dx = longint'(s.x) - ax;
            dy = longint'(s.y) - ay;
            dz = longint'(s.z) - az;
            r1 = run_radius;
            r2 = s.radius;
            if (dx == 0 && dy == 0 && dz == 0) begin
               if (r2 > r1)
                  run_radius = s.radius;
            end else begin
               sum = 72'(mag33(dx)) * 72'(mag33(dx)) + 72'(mag33(dy)) * 72'(mag33(dy))
                   + 72'(mag33(dz)) * 72'(mag33(dz));
               root = '0;
               for (int b = 34; b >= 0; b--) begin
                  cand = root | (36'd1 << b);
                  sq = 72'(cand) * 72'(cand);
                  if (sq <= sum)
                     root = cand;
               end
               cdist = longint'(root);
               if (r1 > cdist + r2) begin
                  // input already inside
               end else if (cdist + r1 < r2) begin
                  run_x = s.x; run_y = s.y; run_z = s.z;
                  run_radius = s.radius;
               end else begin
                  merges_seen++;
                  num = cdist + r2 - r1;
                  den = cdist * 2;
                  t = (num << FRAC_BITS) / den;
                  rad = (cdist + r1 + r2) >> 1;
                  if (t > (64'd1 << FRAC_BITS))
                     t = 64'd1 << FRAC_BITS;
                  run_x = shift_axis(ax, dx, t, sat);
                  run_y = shift_axis(ay, dy, t, sat);
                  run_z = shift_axis(az, dz, t, sat);
                  if (rad > 64'h7FFF_FFFF) begin
                     rad = 64'h7FFF_FFFF;
                     sat = 1;
                  end
                  run_radius = radius_type'(rad);
               end
            end
         end
      end
      o.x = run_x; o.y = run_y; o.z = run_z;
      o.radius = run_radius;
      o.weight = run_weight;
      o.saturated = sat;
      return o;
   endfunction

   // one beat; called and returning at a falling edge
   task automatic send_sphere(sphere_in_type s);
      int gap;
      int pick;
      pick = $urandom_range(99);
      gap = (pick < 60) ? 0 : (pick < 95) ? $urandom_range(3, 1) : $urandom_range(80, 20);
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.in_x = s.x;
      req_if.in_y = s.y;
      req_if.in_z = s.z;
      req_if.in_radius = s.radius;
      req_if.in_weight = s.weight;
      req_if.start_new = s.start_new;
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      pending_spheres.push_back(fold_sphere(s));
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_if.valid = 1'b0;
      while (pending_spheres.size() != 0) @(negedge clock);
   endtask

   function automatic sphere_in_type make_sphere(coord_type x, coord_type y, coord_type z,
                                                 radius_type r, coord_type w, logic st);
      sphere_in_type s;
      s.x = x; s.y = y; s.z = z; s.radius = r; s.weight = w; s.start_new = st;
      return s;
   endfunction

   function automatic coord_type near_coord(int span);
      return coord_type'($signed($urandom_range(2 * span)) - span);
   endfunction

   // mostly nearby spheres so merges, containment and copies all come up
   function automatic sphere_in_type shaped_sphere();
      sphere_in_type s;
      int kind;
      int span;
      kind = $urandom_range(99);
      span = (kind < 50) ? 32'h0004_0000 : (kind < 80) ? 32'h0100_0000 : 32'h2000_0000;
      s.x = near_coord(span);
      s.y = near_coord(span);
      s.z = near_coord(span);
      s.radius = radius_type'($urandom_range(span, 1));
      s.weight = coord_type'($urandom);
      s.start_new = ($urandom_range(99) < 6);
      if ($urandom_range(99) < 5)
         s.radius = '0;
      if ($urandom_range(99) < 4) begin
         s.x = run_x; s.y = run_y; s.z = run_z;
      end
      if ($urandom_range(99) < 3)
         s.radius = radius_type'($urandom) | 31'h4000_0000;
      return s;
   endfunction

   task automatic test_directed();
      localparam coord_type MAXC = 32'sh7FFF_FFFF;
      localparam coord_type MINC = 32'sh8000_0000;
      localparam radius_type MAXR = 31'h7FFF_FFFF;
      // empty input into empty state, then a copy
      send_sphere(make_sphere(32'sh10000, 0, 0, 31'h0, 32'sh20000, 1'b0));
      send_sphere(make_sphere(32'sh10000, 32'sh20000, -32'sh30000, 31'h10000, -5, 1'b0));
      // equal centres, larger then smaller
      send_sphere(make_sphere(32'sh10000, 32'sh20000, -32'sh30000, 31'h30000, 7, 1'b0));
      send_sphere(make_sphere(32'sh10000, 32'sh20000, -32'sh30000, 31'h8000, 3, 1'b0));
      // contained, then containing
      send_sphere(make_sphere(32'sh18000, 32'sh20000, -32'sh30000, 31'h1000, 1, 1'b0));
      send_sphere(make_sphere(32'sh20000, 32'sh20000, -32'sh30000, 31'h100000, 2, 1'b0));
      // true merges
      send_sphere(make_sphere(32'sh300000, -32'sh100000, 32'sh50000, 31'h20000, 9, 1'b0));
      send_sphere(make_sphere(-32'sh300000, 32'sh700000, 32'sh1, 31'h1, MINC, 1'b0));
      // start flag with empty input, then start with a sphere
      send_sphere(make_sphere(0, 0, 0, 31'h0, MINC, 1'b1));
      send_sphere(make_sphere(MAXC, MAXC, MAXC, MAXR, MAXC, 1'b1));
      // opposite corners with full radius: radius clips
      send_sphere(make_sphere(MINC, MINC, MINC, MAXR, MINC, 1'b0));
      send_sphere(make_sphere(MAXC, MINC, MAXC, MAXR, 0, 1'b0));
      send_sphere(make_sphere(MINC, MINC, MINC, 31'h1, -1, 1'b1));
      send_sphere(make_sphere(MAXC, MAXC, MAXC, 31'h1, MAXC, 1'b0));
      send_sphere(make_sphere(MAXC, MAXC, MAXC - 1, 31'h1, 0, 1'b0));
      wait_drained();
   endtask

   task automatic test_shaped_stream(int count);
      for (int i = 0; i < count; i++)
         send_sphere(shaped_sphere());
      wait_drained();
   endtask

   task automatic test_full_range(int count);
      sphere_in_type s;
      for (int i = 0; i < count; i++) begin
         s.x = coord_type'($urandom);
         s.y = coord_type'($urandom);
         s.z = coord_type'($urandom);
         s.radius = radius_type'($urandom);
         s.weight = coord_type'($urandom);
         s.start_new = 1'($urandom_range(1));
         send_sphere(s);
      end
      wait_drained();
   endtask

   // receiver stalls while the sender keeps offering beats
   task automatic test_backpressure();
      hold_rsp = 1;
      for (int i = 0; i < 30; i++)
         send_sphere(shaped_sphere());
      wait_drained();
   endtask

   // response side: random stalls, a long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_if.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 0;
         end else if (stall_left > 0) begin
            rsp_if.ready = 1'b0;
            stall_left--;
            @(negedge clock);
         end else begin
            rsp_if.ready = 1'b1;
            case ($urandom_range(19))
               0, 1, 2: stall_left = $urandom_range(3, 1);
               3:       stall_left = $urandom_range(60, 10);
               default: stall_left = 0;
            endcase
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      sphere_out_type exp_s;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_spheres.size() == 0) begin
            $display("%0t: result beat with nothing expected", $time);
            errors++;
         end else begin
            exp_s = pending_spheres.pop_front();
            beats_checked++;
            if (exp_s.saturated) sat_seen++;
            if (rsp_if.out_x !== exp_s.x) begin
               $display("%0t: out_x exp %h got %h", $time, exp_s.x, rsp_if.out_x);
               errors++;
            end
            if (rsp_if.out_y !== exp_s.y) begin
               $display("%0t: out_y exp %h got %h", $time, exp_s.y, rsp_if.out_y);
               errors++;
            end
            if (rsp_if.out_z !== exp_s.z) begin
               $display("%0t: out_z exp %h got %h", $time, exp_s.z, rsp_if.out_z);
               errors++;
            end
            if (rsp_if.out_radius !== exp_s.radius) begin
               $display("%0t: out_radius exp %h got %h", $time, exp_s.radius,
                        rsp_if.out_radius);
               errors++;
            end
            if (rsp_if.out_weight !== exp_s.weight) begin
               $display("%0t: out_weight exp %h got %h", $time, exp_s.weight,
                        rsp_if.out_weight);
               errors++;
            end
            if (rsp_if.saturated !== exp_s.saturated) begin
               $display("%0t: saturated exp %b got %b", $time, exp_s.saturated,
                        rsp_if.saturated);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.in_x = '0;
      req_if.in_y = '0;
      req_if.in_z = '0;
      req_if.in_radius = '0;
      req_if.in_weight = '0;
      req_if.start_new = 1'b0;
      run_x = '0; run_y = '0; run_z = '0; run_radius = '0; run_weight = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_shaped_stream(800);
      test_backpressure();
      test_full_range(400);
      test_shaped_stream(800);
      wait_drained();
      repeat (300) @(posedge clock);
      $display("%0d beats sent, %0d results checked", beats_sent, beats_checked);
      $display("%0d true merges, %0d saturated results", merges_seen, sat_seen);
      if (errors == 0 && pending_spheres.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
